// ----- hw/rtl/sfr_pkg.sv -----
// shared types and constants for the stuffed frame receiver
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package sfr_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'd85;
    localparam logic [6:0] LEN_MAX   = 7'd127;

    // one result item as it travels to the output queue
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       frame_end;
        logic       frame_abort;
    } t_result;

endpackage

// ----- hw/rtl/sfr_deframer.sv -----
// per-byte header detection, length capture and de-stuffing
// depends on sfr_pkg for the sync byte, length limit and result type
`timescale 1ns / 1ps

module sfr_deframer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_rx_byte,
    output logic             o_res_valid,
    output sfr_pkg::t_result o_res
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [6:0] r_bytes_left, n_bytes_left;
    logic [7:0] r_prior_byte;

    logic       w_header;
    logic [6:0] w_len;

    assign w_header = (i_rx_byte == sfr_pkg::SYNC_BYTE) && (r_prior_byte == sfr_pkg::SYNC_BYTE);

    // zero stands for the sync value, anything above the counter range saturates
    always_comb begin
        if (i_rx_byte == 8'd0) begin
            w_len = sfr_pkg::SYNC_BYTE[6:0];
        end else if (i_rx_byte[7]) begin
            w_len = sfr_pkg::LEN_MAX;
        end else begin
            w_len = i_rx_byte[6:0];
        end
    end

    always_comb begin
        n_phase            = r_phase;
        n_bytes_left       = r_bytes_left;
        o_res_valid        = 1'b0;
        o_res.payload_byte = i_rx_byte;
        o_res.frame_end    = 1'b0;
        o_res.frame_abort  = 1'b0;
        if (w_header) begin
            // restart wins over stuffing
            o_res_valid        = (r_phase == PH_DATA);
            o_res.payload_byte = 8'd0;
            o_res.frame_abort  = 1'b1;
            n_phase            = PH_LEN;
            n_bytes_left       = 7'd0;
        end else begin
            unique case (r_phase)
                PH_LEN: begin
                    n_bytes_left = w_len;
                    n_phase      = PH_DATA;
                end
                PH_DATA: begin
                    if ((i_rx_byte == 8'd0) && (r_prior_byte == sfr_pkg::SYNC_BYTE)) begin
                        // stuffing byte, dropped
                        o_res_valid = 1'b0;
                    end else if (r_bytes_left <= 7'd1) begin
                        o_res_valid     = 1'b1;
                        o_res.frame_end = 1'b1;
                        n_bytes_left    = 7'd0;
                        n_phase         = PH_IDLE;
                    end else begin
                        o_res_valid  = 1'b1;
                        n_bytes_left = r_bytes_left - 7'd1;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bytes_left <= 7'd0;
            r_prior_byte <= 8'd0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_prior_byte <= i_rx_byte;
        end
    end

endmodule

// ----- hw/rtl/sfr_out_queue.sv -----
// two-entry result queue that parts the input side from the output side
// depends on sfr_pkg for the result type
`timescale 1ns / 1ps

module sfr_out_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sfr_pkg::t_result i_push_data,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_pop,
    output sfr_pkg::t_result o_data
);

    sfr_pkg::t_result r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    logic w_push;
    logic w_pop;

    assign o_space = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_space;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("result queue over-filled");

    a_ptrs_match_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_count == 2'd1) == (r_wr_ptr != r_rd_ptr)))
        else $error("queue pointers disagree with fill count");

    a_push_only_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + 2'd1))
        else $error("push without pop did not grow the queue");

    a_pop_only_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (r_count == $past(r_count) - 2'd1))
        else $error("pop without push did not shrink the queue");

endmodule

// ----- hw/rtl/stuffed_frame_receiver_core.sv -----
// top level of the stuffed frame receiver: deframer and result queue
// depends on sfr_pkg, sfr_deframer and sfr_out_queue
`timescale 1ns / 1ps

// usage
//   slave channel: one raw serial byte per request on i_s_axis_tdata.
//   master channel: de-stuffed payload bytes. tlast marks the last byte of a
//   frame, tuser[0] marks an abort (tdata zero) when a fresh 85 85 header
//   arrives part way through a frame.
//   frames are 85 85 LEN DATA..., length 0 meaning 85, lengths above 127
//   saturating at 127; a 0 that follows an 85 in the payload is dropped.
//   a byte that yields no result (header, length, stuffing) is simply absorbed.
// timing
//   one byte accepted every cycle while the queue has space; a result is queued
//   as its byte is accepted, behind any results not yet taken. the state update
//   is a single step per byte, and a two-entry result queue sets the buffering.
//   if the master side stalls, the queue fills and o_s_axis_tready drops once
//   both entries are held; it rises again as soon as one result is taken.
// reset
//   synchronous, active low: phase idle, byte count and previous byte zero,
//   result queue empty.

module stuffed_frame_receiver_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] rx_byte
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] payload_byte
    output logic       o_m_axis_tlast,   // frame_end
    output logic [0:0] o_m_axis_tuser    // [0] frame_abort
);

    logic             w_accept;
    logic             w_res_valid;
    sfr_pkg::t_result w_res;
    sfr_pkg::t_result w_out;

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    sfr_deframer u_deframer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_rx_byte   (i_s_axis_tdata),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    sfr_out_queue u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_accept && w_res_valid),
        .i_push_data (w_res),
        .o_space     (o_s_axis_tready),
        .o_valid     (o_m_axis_tvalid),
        .i_pop       (i_m_axis_tready),
        .o_data      (w_out)
    );

    assign o_m_axis_tdata    = w_out.payload_byte;
    assign o_m_axis_tlast    = w_out.frame_end;
    assign o_m_axis_tuser[0] = w_out.frame_abort;

endmodule

// ----- dv/stuffed_frame_receiver_core_tb.sv -----
// self-checking testbench for stuffed_frame_receiver_core: random and directed byte streams
// depends on sfr_pkg and the core; a built-in deframer predicts every result
`timescale 1ns / 1ps

module testbench;

    typedef enum logic [1:0] {
        RX_IDLE    = 2'd0,
        RX_LENGTH  = 2'd1,
        RX_PAYLOAD = 2'd2
    } t_rx_phase;

    typedef struct {
        logic [7:0] rx_byte;
        bit         drain_first;
        int         idle_pct;
        int         stall_pct;
    } t_line_byte;

    localparam int MAX_REPORTS = 10;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata = 8'd0;   // [7:0] rx_byte
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;          // [7:0] payload_byte
    logic       o_m_axis_tlast;          // frame_end
    logic [0:0] o_m_axis_tuser;          // [0] frame_abort

    t_line_byte       line_bytes[$];
    sfr_pkg::t_result results_due[$];

    // deframer state mirrored from the block
    t_rx_phase  rx_phase;
    logic [6:0] rx_left;
    logic [7:0] rx_prior;

    int         gen_idle_pct;
    int         gen_stall_pct;
    int         stall_pct = 0;
    int         bytes_queued = 0;
    int         bytes_taken = 0;
    int         results_seen = 0;
    int         mismatches = 0;

    t_line_byte       drv_byte;
    sfr_pkg::t_result drv_res;
    sfr_pkg::t_result mon_exp;

    stuffed_frame_receiver_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // returns 1 when the byte produces a result
    function automatic bit deframe_byte(input logic [7:0] rx, output sfr_pkg::t_result res);
        logic [7:0] prev;
        logic [7:0] len;
        prev = rx_prior;
        rx_prior = rx;
        res = '0;
        deframe_byte = 1'b0;
        if (rx == sfr_pkg::SYNC_BYTE && prev == sfr_pkg::SYNC_BYTE) begin
            // a header always wins over stuffing
            if (rx_phase == RX_PAYLOAD) begin
                res.frame_abort = 1'b1;
                deframe_byte = 1'b1;
            end
            rx_phase = RX_LENGTH;
            rx_left = '0;
        end else if (rx_phase == RX_LENGTH) begin
            len = (rx == 8'd0) ? sfr_pkg::SYNC_BYTE : rx;
            rx_left = (len > sfr_pkg::LEN_MAX) ? sfr_pkg::LEN_MAX : len[6:0];
            rx_phase = RX_PAYLOAD;
        end else if (rx_phase == RX_PAYLOAD) begin
            if (!(rx == 8'd0 && prev == sfr_pkg::SYNC_BYTE)) begin
                res.payload_byte = rx;
                deframe_byte = 1'b1;
                if (rx_left <= 7'd1) begin
                    res.frame_end = 1'b1;
                    rx_left = '0;
                    rx_phase = RX_IDLE;
                end else begin
                    rx_left = rx_left - 7'd1;
                end
            end
        end else begin
            rx_phase = RX_IDLE;
        end
    endfunction

    task automatic queue_byte(input logic [7:0] b, input bit drain = 1'b0);
        t_line_byte lb;
        lb.rx_byte = b;
        lb.drain_first = drain || ($urandom_range(99) == 0);
        lb.idle_pct = gen_idle_pct;
        lb.stall_pct = gen_stall_pct;
        line_bytes.insert(line_bytes.size(), lb);
        bytes_queued++;
    endtask

    // biased towards the sync value and zero so that stuffing and headers show up
    function automatic logic [7:0] line_noise();
        int r;
        r = $urandom_range(9);
        if (r < 2)
            return sfr_pkg::SYNC_BYTE;
        else if (r == 2)
            return 8'd0;
        return 8'($urandom_range(255));
    endfunction

    task automatic queue_frame(input logic [7:0] len_byte, input bit cut_short);
        int count;
        int sent;
        logic [7:0] b;
        count = (len_byte == 8'd0) ? 85 : ((len_byte > sfr_pkg::LEN_MAX) ? 127 : len_byte);
        if (cut_short && count > 1)
            count = $urandom_range(1, count - 1);
        queue_byte(sfr_pkg::SYNC_BYTE);
        queue_byte(sfr_pkg::SYNC_BYTE);
        queue_byte(len_byte);
        for (sent = 0; sent < count; sent++) begin
            b = line_noise();
            queue_byte(b);
            // the sender stuffs a zero after every sync value, almost always
            if (b == sfr_pkg::SYNC_BYTE && $urandom_range(9) != 0)
                queue_byte(8'd0);
        end
    endtask

    task automatic queue_phase(input int idle_pct, input int stall_pct_in, input int target);
        int start;
        int r;
        int n;
        logic [7:0] len_byte;
        gen_idle_pct = idle_pct;
        gen_stall_pct = stall_pct_in;
        start = bytes_queued;
        // first request of the phase waits for every outstanding result
        queue_byte(line_noise(), 1'b1);
        while (bytes_queued - start < target) begin
            r = $urandom_range(99);
            if (r < 3)
                len_byte = 8'd0;
            else if (r < 6)
                len_byte = 8'($urandom_range(128, 255));
            else if (r < 11)
                len_byte = 8'($urandom_range(9, 127));
            else
                len_byte = 8'($urandom_range(1, 8));
            queue_frame(len_byte, $urandom_range(9) == 0);
            if ($urandom_range(9) < 3) begin
                n = $urandom_range(1, 4);
                repeat (n) queue_byte(line_noise());
            end
        end
    endtask

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch: %s", msg);
    endtask

    // sender side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            rx_phase = RX_IDLE;
            rx_left = '0;
            rx_prior = '0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                if (deframe_byte(i_s_axis_tdata, drv_res))
                    results_due.insert(results_due.size(), drv_res);
                bytes_taken++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (line_bytes.size() != 0
                        && !(line_bytes[0].drain_first && results_due.size() != 0)
                        && $urandom_range(99) >= line_bytes[0].idle_pct) begin
                    drv_byte = line_bytes.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata <= drv_byte.rx_byte;
                    stall_pct <= drv_byte.stall_pct;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                results_seen++;
                if (results_due.size() == 0) begin
                    note_mismatch($sformatf("result %0d unexpected: data %02h last %0b abort %0b",
                        results_seen, o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser[0]));
                end else begin
                    mon_exp = results_due.pop_front();
                    if (o_m_axis_tdata !== mon_exp.payload_byte
                            || o_m_axis_tlast !== mon_exp.frame_end
                            || o_m_axis_tuser[0] !== mon_exp.frame_abort)
                        note_mismatch($sformatf(
                            "result %0d exp data %02h last %0b abort %0b, got %02h %0b %0b",
                            results_seen, mon_exp.payload_byte, mon_exp.frame_end,
                            mon_exp.frame_abort, o_m_axis_tdata, o_m_axis_tlast,
                            o_m_axis_tuser[0]));
                end
            end
            i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        gen_idle_pct = 0;
        gen_stall_pct = 0;

        // idle bytes at both extremes, no result
        queue_byte(8'h00);
        queue_byte(8'hff);
        // short frame with extreme payload values
        queue_byte(sfr_pkg::SYNC_BYTE); queue_byte(sfr_pkg::SYNC_BYTE); queue_byte(8'd2);
        queue_byte(8'hff); queue_byte(8'h00);
        // repeated sync in the length phase, then a payload sync with its stuffing zero,
        // then a payload sync ending the frame right before a new header
        queue_byte(sfr_pkg::SYNC_BYTE); queue_byte(sfr_pkg::SYNC_BYTE);
        queue_byte(sfr_pkg::SYNC_BYTE);
        queue_byte(8'd2);
        queue_byte(sfr_pkg::SYNC_BYTE); queue_byte(8'd0); queue_byte(sfr_pkg::SYNC_BYTE);
        // header arrives after the last byte, then mid-frame: abort with length zero
        queue_byte(sfr_pkg::SYNC_BYTE); queue_byte(8'd0);
        queue_byte(8'h5a); queue_byte(8'ha5);
        // header part way through the frame aborts it; oversized length saturates
        queue_byte(sfr_pkg::SYNC_BYTE); queue_byte(sfr_pkg::SYNC_BYTE); queue_byte(8'd200);
        queue_byte(8'h01);
        queue_byte(sfr_pkg::SYNC_BYTE); queue_byte(sfr_pkg::SYNC_BYTE); queue_byte(8'd1);
        queue_byte(8'h80);

        queue_phase(0, 0, 290);
        queue_phase(87, 0, 290);
        queue_phase(0, 87, 290);
        queue_phase(15, 15, 290);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_taken != bytes_queued)
            @(posedge i_clk);
        while (results_due.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- stuffed_frame_receiver_core.f -----
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_deframer.sv
hw/rtl/sfr_out_queue.sv
hw/rtl/stuffed_frame_receiver_core.sv
dv/stuffed_frame_receiver_core_tb.sv
